### rtl/bcms_pkg.sv
// bcms_pkg: shared types and constants of the breath cycle motor sequencer
// holds field widths, phase codes, duty levels, register indexes and structs
// no dependencies
package bcms_pkg;

    localparam int CFG_W   = 16;
    localparam int POS_W   = 16;
    localparam int DUTY_W  = 10;
    localparam int PHASE_W = 3;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = 3;

    typedef logic [PHASE_W-1:0] phase_t;

    // breath phases
    localparam phase_t PH_START  = 3'd0;
    localparam phase_t PH_OPEN   = 3'd1;
    localparam phase_t PH_GO     = 3'd2;
    localparam phase_t PH_RAMP   = 3'd3;
    localparam phase_t PH_HOLD   = 3'd4;
    localparam phase_t PH_EXHALE = 3'd5;

    localparam logic [DUTY_W-1:0] DUTY_STOP   = 10'd0;
    localparam logic [DUTY_W-1:0] DUTY_OPEN   = 10'd200;
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 10'd1023;
    localparam logic [DUTY_W-1:0] DUTY_EXHALE = 10'd300;

    localparam logic DIR_EXHALE = 1'b0;
    localparam logic DIR_INHALE = 1'b1;

    // register indexes, byte address 4*index
    localparam logic [REG_IDX_W-1:0] REG_OPEN_MIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RAMPUP     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VOL_TARGET = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INHALE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EXHALE     = 3'd4;

    localparam logic [CFG_W-1:0] RST_OPEN_MIN   = 16'd64;
    localparam logic [CFG_W-1:0] RST_RAMPUP     = 16'd50;
    localparam logic [CFG_W-1:0] RST_VOL_TARGET = 16'd32768;
    localparam logic [CFG_W-1:0] RST_INHALE     = 16'd150;
    localparam logic [CFG_W-1:0] RST_EXHALE     = 16'd250;

    typedef struct packed {
        logic [CFG_W-1:0] open_position_min;
        logic [CFG_W-1:0] rampup_ticks;
        logic [CFG_W-1:0] volume_target_position;
        logic [CFG_W-1:0] inhale_ticks;
        logic [CFG_W-1:0] exhale_ticks;
    } cfg_t;

    typedef struct packed {
        logic              drive_inhale;
        logic [DUTY_W-1:0] drive_duty;
        phase_t            phase_now;
        logic              cycle_done;
    } result_t;

endpackage

### rtl/bcms_apb_regs.sv
// bcms_apb_regs: apb-style configuration registers of the sequencer
// depends on bcms_pkg for register indexes, reset values and cfg_t
module bcms_apb_regs
    import bcms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_val  = pwdata[CFG_W-1:0];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_position_min      <= RST_OPEN_MIN;
            cfg_reg.rampup_ticks           <= RST_RAMPUP;
            cfg_reg.volume_target_position <= RST_VOL_TARGET;
            cfg_reg.inhale_ticks           <= RST_INHALE;
            cfg_reg.exhale_ticks           <= RST_EXHALE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OPEN_MIN:   cfg_reg.open_position_min      <= wr_val;
                REG_RAMPUP:     cfg_reg.rampup_ticks           <= wr_val;
                REG_VOL_TARGET: cfg_reg.volume_target_position <= wr_val;
                REG_INHALE:     cfg_reg.inhale_ticks           <= wr_val;
                REG_EXHALE:     cfg_reg.exhale_ticks           <= wr_val;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OPEN_MIN:   prdata = APB_DW'(cfg_reg.open_position_min);
            REG_RAMPUP:     prdata = APB_DW'(cfg_reg.rampup_ticks);
            REG_VOL_TARGET: prdata = APB_DW'(cfg_reg.volume_target_position);
            REG_INHALE:     prdata = APB_DW'(cfg_reg.inhale_ticks);
            REG_EXHALE:     prdata = APB_DW'(cfg_reg.exhale_ticks);
            default:        prdata = '0;
        endcase
    end

endmodule

### rtl/bcms_step.sv
// bcms_step: breath phase state, phase timer and held drive, one step per item
// depends on bcms_pkg for phase codes, duty levels, cfg_t and result_t
module bcms_step
    import bcms_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [POS_W-1:0] pos,
    input  cfg_t             cfg,
    output result_t          res
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    phase_t                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [DUTY_W-1:0]       duty_reg, duty_next;
    logic                    dir_reg, dir_next;
    logic                    done;
    logic [TIMER_BITS-1:0]   timer_inc;
    logic [CMP_W-1:0]        timer_cmp;
    logic                    pos_open;

    // saturating increment
    assign timer_inc = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
    assign timer_cmp = CMP_W'(timer_inc);
    assign pos_open  = pos < cfg.open_position_min;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        duty_next  = duty_reg;
        dir_next   = dir_reg;
        done       = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                dir_next   = DIR_EXHALE;
                duty_next  = DUTY_OPEN;
                phase_next = PH_OPEN;
            end
            PH_OPEN:
            begin
                if (pos_open)
                begin
                    duty_next  = DUTY_STOP;
                    phase_next = PH_GO;
                end
            end
            PH_GO:
            begin
                dir_next   = DIR_INHALE;
                duty_next  = DUTY_FULL;
                timer_next = '0;
                phase_next = PH_RAMP;
            end
            PH_RAMP:
            begin
                timer_next = timer_inc;
                if (timer_cmp >= CMP_W'(cfg.rampup_ticks))
                begin
                    timer_next = '0;
                    duty_next  = DUTY_FULL;
                    phase_next = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                timer_next = timer_inc;
                if (pos >= cfg.volume_target_position ||
                    timer_cmp > CMP_W'(cfg.inhale_ticks))
                begin
                    timer_next = '0;
                    duty_next  = DUTY_EXHALE;
                    dir_next   = DIR_EXHALE;
                    phase_next = PH_EXHALE;
                end
            end
            PH_EXHALE:
            begin
                timer_next = timer_inc;
                if (pos_open)
                begin
                    duty_next = DUTY_STOP;
                end
                if (timer_cmp > CMP_W'(cfg.exhale_ticks))
                begin
                    duty_next  = DUTY_STOP;
                    phase_next = PH_START;
                    done       = 1'b1;
                end
            end
            default:
            begin
                duty_next  = DUTY_STOP;
                phase_next = PH_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            timer_reg <= '0;
            duty_reg  <= DUTY_STOP;
            dir_reg   <= DIR_EXHALE;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            duty_reg  <= duty_next;
            dir_reg   <= dir_next;
        end
    end

    assign res.drive_inhale = dir_next;
    assign res.drive_duty   = duty_next;
    assign res.phase_now    = phase_next;
    assign res.cycle_done   = done;

endmodule

### rtl/breath_cycle_motor_sequencer_core.sv
// breath_cycle_motor_sequencer_core: top level of the breath cycle sequencer
// depends on bcms_pkg, bcms_apb_regs and bcms_step
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-------------------------------------------
//   tick in  | input     | in_valid/ready   | motor_position
//   drive out| output    | out_valid/ready  | drive_inhale, drive_duty, phase_now, cycle_done
//   config   | input     | apb psel/penable | paddr, pwdata, prdata
//
// one item per clock cycle sustained while the output is not stalled
// the item passes an input register, one step of the phase logic, then the result register
// reset puts the sequence at start with the motor stopped and registers at defaults
// a stalled output holds its result; the input register refills while the result waits
// the phase state advances only when the item moves into the result register
module breath_cycle_motor_sequencer_core
    import bcms_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [POS_W-1:0]  motor_position,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              drive_inhale,
    output logic [DUTY_W-1:0] drive_duty,
    output phase_t            phase_now,
    output logic              cycle_done
);

    cfg_t             cfg;
    logic             in_vld_reg;
    logic [POS_W-1:0] pos_reg;
    logic             out_vld_reg;
    result_t          res_reg;
    result_t          step_res;
    logic             out_take;
    logic             step_en;

    bcms_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcms_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .pos     (pos_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign out_take = !out_vld_reg || out_ready;
    assign step_en  = in_vld_reg && out_take;
    assign in_ready = !in_vld_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pos_reg <= motor_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign drive_inhale = res_reg.drive_inhale;
    assign drive_duty   = res_reg.drive_duty;
    assign phase_now    = res_reg.phase_now;
    assign cycle_done   = res_reg.cycle_done;

endmodule

### rtl/bcms_checker.sv
// bcms_checker: port-level assertions on the sequencer top level, with its bind
// depends on bcms_pkg for phase codes and duty levels
module bcms_checker
    import bcms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              drive_inhale,
    input logic [DUTY_W-1:0] drive_duty,
    input phase_t            phase_now,
    input logic              cycle_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_inhale) &&
        $stable(drive_duty) && $stable(phase_now) && $stable(cycle_done))
        else $error("stalled result changed");

    // end of cycle always lands at start
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cycle_done |-> phase_now == PH_START)
        else $error("cycle_done without return to start");

    // inhale phases drive closing at full duty
    a_inhale_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase_now == PH_RAMP || phase_now == PH_HOLD) |->
        drive_inhale == DIR_INHALE && drive_duty == DUTY_FULL)
        else $error("inhale phase without full inhale drive");

    // back at start the motor is stopped in exhale direction
    a_start_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_now == PH_START |->
        drive_inhale == DIR_EXHALE && drive_duty == DUTY_STOP)
        else $error("start phase with motor driven");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind breath_cycle_motor_sequencer_core bcms_checker u_bcms_checker (.*);
